/* rtl/des_pkg.sv */
// ----------------------------------------------------------------------------
// des_pkg
// constants, permutation tables and round functions for the des block cipher
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned BlockW    = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned SubkeyW   = 48;
  localparam int unsigned CdW       = 56;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef logic [7:0] tab8_t [64];

  localparam tab8_t TabIp = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam tab8_t TabFp = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // tables count bits from 1 at the msb
  function automatic logic [63:0] perm64(input logic [63:0] v, input tab8_t t);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(t[i])];
    return r;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] k);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = k[64 - int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] pc2(input logic [55:0] cd);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = cd[56 - int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input int s);
    logic [27:0] r;
    r = (s == 1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    return r;
  endfunction

  // right rotate, undoes one left step of the schedule
  function automatic logic [27:0] rotr28(input logic [27:0] v, input int s);
    logic [27:0] r;
    r = (s == 1) ? {v[0], v[27:1]} : {v[1:0], v[27:2]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] h, input logic [47:0] sk);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] r;
    for (int i = 0; i < 48; i++) x[47-i] = h[32 - int'(TabE[i])];
    x = x ^ sk;
    for (int i = 0; i < 8; i++) begin
      six = x[42 - 6*i +: 6];
      s[28 - 4*i +: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) r[31-i] = s[32 - int'(TabP[i])];
    return r;
  endfunction

endpackage

/* rtl/des_block_cipher.sv */
// ----------------------------------------------------------------------------
// des_block_cipher
// des ecb engine, sixteen registered round cells in a chain
// ----------------------------------------------------------------------------
// usage:
//   s_axis: tdata = block_in[63:0], tuser = cmd (0 encrypt, 1 decrypt)
//   m_axis: tdata = block_out[63:0]
//   apb: cipher_key at byte address 0 (64-bit data), write only while idle
// one transaction per cycle enters the chain of sixteen round cells unless it
// stalls; each cell holds one block, its key halves and its own round of the
// schedule. a block passes the cells and then the output register that raises
// tvalid, throughput one block per cycle. the whole chain advances as one:
// when the output register is full and m_axis_tready is low, the chain stalls
// and s_axis_tready drops. reset empties the chain and clears the key.
// ----------------------------------------------------------------------------
module des_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // block_in[63:0]
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // block_out[63:0]
);
  import des_pkg::*;

  logic [63:0] cipher_key;
  logic        en;
  logic [63:0] ip;
  logic [55:0] cd0;

  logic        v  [NumRounds+1];
  logic        dc [NumRounds+1];
  logic [27:0] c  [NumRounds+1];
  logic [27:0] d  [NumRounds+1];
  logic [31:0] l  [NumRounds+1];
  logic [31:0] r  [NumRounds+1];

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? cipher_key : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      cipher_key <= pwdata;
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // decrypt starts from the fully rotated key, which equals pc1 after 28 steps
  assign ip    = perm64(s_axis_tdata, TabIp);
  assign cd0   = pc1(cipher_key);
  assign v[0]  = s_axis_tvalid;
  assign dc[0] = (s_axis_tuser[0] == CMD_DECRYPT);
  assign c[0]  = cd0[55:28];
  assign d[0]  = cd0[27:0];
  assign l[0]  = ip[63:32];
  assign r[0]  = ip[31:0];

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    des_round_cell #(.Round(g)) u_cell (
      .clk, .rst, .en,
      .in_valid(v[g]), .in_dec(dc[g]), .in_c(c[g]), .in_d(d[g]),
      .in_l(l[g]), .in_r(r[g]),
      .out_valid(v[g+1]), .out_dec(dc[g+1]), .out_c(c[g+1]), .out_d(d[g+1]),
      .out_l(l[g+1]), .out_r(r[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= perm64({r[NumRounds], l[NumRounds]}, TabFp);
    end
  end

endmodule

/* rtl/des_round_cell.sv */
// ----------------------------------------------------------------------------
// des_round_cell
// one feistel round with its own key schedule step, registered
// ----------------------------------------------------------------------------
module des_round_cell #(
  parameter int unsigned Round = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic        in_dec,
  input  logic [27:0] in_c,
  input  logic [27:0] in_d,
  input  logic [31:0] in_l,
  input  logic [31:0] in_r,
  output logic        out_valid,
  output logic        out_dec,
  output logic [27:0] out_c,
  output logic [27:0] out_d,
  output logic [31:0] out_l,
  output logic [31:0] out_r
);
  import des_pkg::*;

  logic [27:0] c_k, d_k, c_next, d_next;
  logic [47:0] sk;

  // encrypt rotates left before the round, decrypt uses the key then rotates right
  always_comb begin
    if (in_dec) begin
      c_k    = in_c;
      d_k    = in_d;
      c_next = rotr28(in_c, int'(TabRot[NumRounds-1-Round]));
      d_next = rotr28(in_d, int'(TabRot[NumRounds-1-Round]));
    end else begin
      c_k    = rotl28(in_c, int'(TabRot[Round]));
      d_k    = rotl28(in_d, int'(TabRot[Round]));
      c_next = c_k;
      d_next = d_k;
    end
    sk = pc2({c_k, d_k});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dec <= in_dec;
      out_c   <= c_next;
      out_d   <= d_next;
      out_l   <= in_r;
      out_r   <= in_l ^ feistel(in_r, sk);
    end
  end

endmodule
